// ----- design/cll_pkg.sv -----
`timescale 1ns / 1ps
// Package for the C-style lexer: token and queue record types, lexer modes,
// token kinds, character codes and character class functions.
// No dependencies.
package cll_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int Q_DEPTH             = 4;
    localparam int Q_PTR_BITS          = 2;
    localparam int Q_CNT_BITS          = 3;

    localparam logic [3:0] K_END     = 4'd0;
    localparam logic [3:0] K_LPAREN  = 4'd1;
    localparam logic [3:0] K_RPAREN  = 4'd2;
    localparam logic [3:0] K_LBRACK  = 4'd3;
    localparam logic [3:0] K_RBRACK  = 4'd4;
    localparam logic [3:0] K_LBRACE  = 4'd5;
    localparam logic [3:0] K_RBRACE  = 4'd6;
    localparam logic [3:0] K_COLON   = 4'd7;
    localparam logic [3:0] K_SEMI    = 4'd8;
    localparam logic [3:0] K_STAR    = 4'd9;
    localparam logic [3:0] K_STRING  = 4'd10;
    localparam logic [3:0] K_IDENT   = 4'd11;
    localparam logic [3:0] K_UNKNOWN = 4'd12;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_SLASH = 3'd1,
        M_LINE  = 3'd2,
        M_BLOCK = 3'd3,
        M_BSTAR = 3'd4,
        M_IDENT = 3'd5,
        M_STR   = 3'd6,
        M_ESC   = 3'd7
    } t_mode;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
    } t_token;

    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_rec;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_ident_tail(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
               is_eol(c);
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACK: k = K_LBRACK;
            CH_RBRACK: k = K_RBRACK;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_COLON:  k = K_COLON;
            CH_SEMI:   k = K_SEMI;
            CH_STAR:   k = K_STAR;
            default:   k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// ----- design/cll_front.sv -----
`timescale 1ns / 1ps
// Lexer front end: accepts text bytes, runs the mode machine and builds one
// queue record of up to two tokens per byte. Depends on cll_pkg.
module cll_front #(
    parameter int OFFSET_BITS = cll_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_text_byte,
    output logic          o_ready,
    input  logic          i_q_ready,
    output logic          o_push,
    output cll_pkg::t_rec o_rec
);

    localparam int LW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

    cll_pkg::t_mode         r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [OFFSET_BITS-1:0] r_start, n_start;

    logic                   accept;
    logic [OFFSET_BITS-1:0] p_inc;
    logic [OFFSET_BITS-1:0] diff;
    logic [LW-1:0]          diff_ext;
    logic [LW-1:0]          p_ext;
    logic [LW-1:0]          start_ext;
    logic [15:0]            span_len;
    logic                   pre_v, post_v, run_idle;
    cll_pkg::t_token        pre_tok, post_tok;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    assign p_inc     = (r_offset == {OFFSET_BITS{1'b1}}) ? r_offset : r_offset + 1'b1;
    assign diff      = (r_offset > r_start) ? (r_offset - r_start) : '0;
    assign diff_ext  = LW'(diff);
    assign p_ext     = LW'(r_offset);
    assign start_ext = LW'(r_start);
    assign span_len  = (diff_ext > LW'(16'hFFFF)) ? 16'hFFFF : diff_ext[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= cll_pkg::M_IDLE;
            r_offset <= '0;
            r_start  <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_start  <= n_start;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_offset = p_inc;
        n_start  = r_start;
        pre_v    = 1'b0;
        pre_tok  = '0;
        post_v   = 1'b0;
        post_tok = '0;
        run_idle = 1'b0;
        if (i_text_byte == cll_pkg::CH_NUL) begin
            unique case (r_mode)
                cll_pkg::M_IDENT: begin
                    pre_v   = 1'b1;
                    pre_tok = '{cll_pkg::K_IDENT, start_ext[15:0], span_len};
                end
                cll_pkg::M_STR, cll_pkg::M_ESC: begin
                    pre_v   = 1'b1;
                    pre_tok = '{cll_pkg::K_STRING, start_ext[15:0], span_len};
                end
                cll_pkg::M_SLASH: begin
                    pre_v   = 1'b1;
                    pre_tok = '{cll_pkg::K_UNKNOWN, start_ext[15:0], 16'd1};
                end
                default: begin
                end
            endcase
            post_v   = 1'b1;
            post_tok = '{cll_pkg::K_END, p_ext[15:0], 16'd1};
            n_mode   = cll_pkg::M_IDLE;
            n_offset = '0;
            n_start  = '0;
        end else begin
            unique case (r_mode)
                cll_pkg::M_IDLE: begin
                    run_idle = 1'b1;
                end
                cll_pkg::M_SLASH: begin
                    if (i_text_byte == cll_pkg::CH_SLASH) begin
                        n_mode = cll_pkg::M_LINE;
                    end else if (i_text_byte == cll_pkg::CH_STAR) begin
                        n_mode = cll_pkg::M_BLOCK;
                    end else begin
                        pre_v    = 1'b1;
                        pre_tok  = '{cll_pkg::K_UNKNOWN, start_ext[15:0], 16'd1};
                        n_mode   = cll_pkg::M_IDLE;
                        run_idle = 1'b1;
                    end
                end
                cll_pkg::M_LINE: begin
                    if (cll_pkg::is_eol(i_text_byte)) begin
                        n_mode = cll_pkg::M_IDLE;
                    end
                end
                cll_pkg::M_BLOCK: begin
                    if (i_text_byte == cll_pkg::CH_STAR) begin
                        n_mode = cll_pkg::M_BSTAR;
                    end
                end
                cll_pkg::M_BSTAR: begin
                    if (i_text_byte == cll_pkg::CH_SLASH) begin
                        n_mode = cll_pkg::M_IDLE;
                    end else if (i_text_byte != cll_pkg::CH_STAR) begin
                        n_mode = cll_pkg::M_BLOCK;
                    end
                end
                cll_pkg::M_IDENT: begin
                    if (!cll_pkg::is_ident_tail(i_text_byte)) begin
                        pre_v    = 1'b1;
                        pre_tok  = '{cll_pkg::K_IDENT, start_ext[15:0], span_len};
                        n_mode   = cll_pkg::M_IDLE;
                        run_idle = 1'b1;
                    end
                end
                cll_pkg::M_STR: begin
                    if (i_text_byte == cll_pkg::CH_QUOTE) begin
                        pre_v   = 1'b1;
                        pre_tok = '{cll_pkg::K_STRING, start_ext[15:0], span_len};
                        n_mode  = cll_pkg::M_IDLE;
                    end else if (i_text_byte == cll_pkg::CH_BSLASH) begin
                        n_mode = cll_pkg::M_ESC;
                    end
                end
                cll_pkg::M_ESC: begin
                    n_mode = cll_pkg::M_STR;
                end
                default: begin
                end
            endcase
            if (run_idle) begin
                if (cll_pkg::is_space(i_text_byte)) begin
                    n_mode = cll_pkg::M_IDLE;
                end else if (i_text_byte == cll_pkg::CH_SLASH) begin
                    n_mode  = cll_pkg::M_SLASH;
                    n_start = r_offset;
                end else if (i_text_byte == cll_pkg::CH_QUOTE) begin
                    n_mode  = cll_pkg::M_STR;
                    n_start = p_inc;
                end else if (cll_pkg::is_alpha(i_text_byte)) begin
                    n_mode  = cll_pkg::M_IDENT;
                    n_start = r_offset;
                end else begin
                    post_v   = 1'b1;
                    post_tok = '{cll_pkg::punct_kind(i_text_byte), p_ext[15:0], 16'd1};
                end
            end
        end
    end

    assign o_push     = accept && (pre_v || post_v);
    assign o_rec.two  = pre_v && post_v;
    assign o_rec.tok0 = pre_v ? pre_tok : post_tok;
    assign o_rec.tok1 = post_tok;

endmodule

// ----- design/cll_queue.sv -----
`timescale 1ns / 1ps
// Short queue of token records between the lexer front end and the output
// stage. Depends on cll_pkg.
module cll_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cll_pkg::t_rec i_rec,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output cll_pkg::t_rec o_rec
);

    cll_pkg::t_rec                  r_mem [cll_pkg::Q_DEPTH];
    logic [cll_pkg::Q_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [cll_pkg::Q_CNT_BITS-1:0] r_count;

    assign o_ready = (r_count != cll_pkg::Q_CNT_BITS'(cll_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready))
        else $error("Record pushed into a full queue.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("Record popped from an empty queue.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[cll_pkg::Q_PTR_BITS-1:0])
        else $error("Queue pointers disagree with the fill count.");

endmodule

// ----- design/cll_back.sv -----
`timescale 1ns / 1ps
// Output stage: pops token records from the queue and presents one token per
// transaction from an output register. Depends on cll_pkg.
module cll_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  cll_pkg::t_rec i_q_rec,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [3:0]    o_token_kind,
    output logic [15:0]   o_start_offset,
    output logic [15:0]   o_token_length,
    output logic          o_last_of_run
);

    logic            r_valid;
    logic            r_pend;
    cll_pkg::t_token r_tok;
    cll_pkg::t_token r_second;
    logic            r_last;
    logic            out_free;

    assign out_free = !r_valid || i_ready;
    assign o_pop    = out_free && !r_pend && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (i_q_valid) begin
                r_valid <= 1'b1;
                r_pend  <= i_q_rec.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_tok  <= r_second;
                r_last <= 1'b1;
            end else if (i_q_valid) begin
                r_tok    <= i_q_rec.tok0;
                r_last   <= !i_q_rec.two;
                r_second <= i_q_rec.tok1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_token_kind   = r_tok.kind;
    assign o_start_offset = r_tok.start;
    assign o_token_length = r_tok.len;
    assign o_last_of_run  = r_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_valid && !r_last))
        else $error("Second token pending without the first token on the output.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && i_ready) |=> (r_valid && r_last && !r_pend))
        else $error("Pending second token was not presented next.");

endmodule

// ----- design/c_like_lexer.sv -----
`timescale 1ns / 1ps
// C-style lexer top level. The first token of a byte reaches the output through the
// queue and the output register; a second token from the same byte follows once the
// first has been taken. Throughput: one text byte per cycle while the queue has room;
// the output stage presents one token per cycle while the receiver is ready, so bytes
// that close one token and emit another make two-token records, absorbed by a
// four-record queue. Synchronous active-low reset returns the lexer to idle with
// offset and token start at zero and empties the queue.
module c_like_lexer #(
    parameter int OFFSET_BITS = cll_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    logic          q_ready;
    logic          push;
    cll_pkg::t_rec push_rec;
    logic          pop;
    logic          q_valid;
    cll_pkg::t_rec q_rec;

    cll_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_text_byte (i_text_byte),
        .o_ready     (o_ready),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    cll_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    cll_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_rec        (q_rec),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for c_like_lexer: random valid/ready traffic on both sides,
// with a scoreboard class that predicts every token from the accepted text bytes.
// Depends on cll_pkg and the c_like_lexer RTL.
module tb;

    typedef struct {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } t_tok_entry;

    class t_token_scoreboard;
        cll_pkg::t_mode mode;
        logic [15:0]    pos;
        logic [15:0]    tok_start;
        t_tok_entry     run[$];
        t_tok_entry     pending[$];
        int             errors;

        function new();
            mode = cll_pkg::M_IDLE;
            pos = '0;
            tok_start = '0;
            errors = 0;
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function logic [15:0] span(logic [15:0] from, logic [15:0] to);
            return (to <= from) ? 16'd0 : to - from;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        endfunction

        function bit is_newline(logic [7:0] c);
            return c == cll_pkg::CH_LF || c == cll_pkg::CH_CR;
        endfunction

        function void add(logic [3:0] kind, logic [15:0] start, logic [15:0] len);
            t_tok_entry t;
            t.kind = kind;
            t.start = start;
            t.len = len;
            t.last = 1'b0;
            run.push_back(t);
        endfunction

        function void between_tokens(logic [7:0] c, logic [15:0] p);
            logic [3:0] k;
            if (c == cll_pkg::CH_SPACE || c == cll_pkg::CH_TAB || c == cll_pkg::CH_VT ||
                c == cll_pkg::CH_FF || is_newline(c))
                return;
            if (c == cll_pkg::CH_SLASH) begin
                mode = cll_pkg::M_SLASH;
                tok_start = p;
            end else if (c == cll_pkg::CH_QUOTE) begin
                mode = cll_pkg::M_STR;
                tok_start = bump(p);
            end else if (is_letter(c)) begin
                mode = cll_pkg::M_IDENT;
                tok_start = p;
            end else begin
                case (c)
                    cll_pkg::CH_LPAREN: k = cll_pkg::K_LPAREN;
                    cll_pkg::CH_RPAREN: k = cll_pkg::K_RPAREN;
                    cll_pkg::CH_LBRACK: k = cll_pkg::K_LBRACK;
                    cll_pkg::CH_RBRACK: k = cll_pkg::K_RBRACK;
                    cll_pkg::CH_LBRACE: k = cll_pkg::K_LBRACE;
                    cll_pkg::CH_RBRACE: k = cll_pkg::K_RBRACE;
                    cll_pkg::CH_COLON:  k = cll_pkg::K_COLON;
                    cll_pkg::CH_SEMI:   k = cll_pkg::K_SEMI;
                    cll_pkg::CH_STAR:   k = cll_pkg::K_STAR;
                    default:            k = cll_pkg::K_UNKNOWN;
                endcase
                add(k, p, 16'd1);
            end
        endfunction

        function void note_byte(logic [7:0] c);
            logic [15:0] p;
            p = pos;
            run.delete();
            if (c == cll_pkg::CH_NUL) begin
                case (mode)
                    cll_pkg::M_IDENT:
                        add(cll_pkg::K_IDENT, tok_start, span(tok_start, p));
                    cll_pkg::M_STR, cll_pkg::M_ESC:
                        add(cll_pkg::K_STRING, tok_start, span(tok_start, p));
                    cll_pkg::M_SLASH:
                        add(cll_pkg::K_UNKNOWN, tok_start, 16'd1);
                    default: ;
                endcase
                add(cll_pkg::K_END, p, 16'd1);
                mode = cll_pkg::M_IDLE;
                pos = '0;
                tok_start = '0;
            end else begin
                case (mode)
                    cll_pkg::M_IDLE: between_tokens(c, p);
                    cll_pkg::M_SLASH: begin
                        if (c == cll_pkg::CH_SLASH) begin
                            mode = cll_pkg::M_LINE;
                        end else if (c == cll_pkg::CH_STAR) begin
                            mode = cll_pkg::M_BLOCK;
                        end else begin
                            add(cll_pkg::K_UNKNOWN, tok_start, 16'd1);
                            mode = cll_pkg::M_IDLE;
                            between_tokens(c, p);
                        end
                    end
                    cll_pkg::M_LINE: begin
                        if (is_newline(c)) mode = cll_pkg::M_IDLE;
                    end
                    cll_pkg::M_BLOCK: begin
                        if (c == cll_pkg::CH_STAR) mode = cll_pkg::M_BSTAR;
                    end
                    cll_pkg::M_BSTAR: begin
                        if (c == cll_pkg::CH_SLASH) mode = cll_pkg::M_IDLE;
                        else if (c != cll_pkg::CH_STAR) mode = cll_pkg::M_BLOCK;
                    end
                    cll_pkg::M_IDENT: begin
                        if (!(is_letter(c) || (c >= 8'h30 && c <= 8'h39) ||
                              c == cll_pkg::CH_UNDER)) begin
                            add(cll_pkg::K_IDENT, tok_start, span(tok_start, p));
                            mode = cll_pkg::M_IDLE;
                            between_tokens(c, p);
                        end
                    end
                    cll_pkg::M_STR: begin
                        if (c == cll_pkg::CH_QUOTE) begin
                            add(cll_pkg::K_STRING, tok_start, span(tok_start, p));
                            mode = cll_pkg::M_IDLE;
                        end else if (c == cll_pkg::CH_BSLASH) begin
                            mode = cll_pkg::M_ESC;
                        end
                    end
                    default: mode = cll_pkg::M_STR;
                endcase
                pos = bump(p);
            end
            if (run.size() > 0) run[run.size() - 1].last = 1'b1;
            foreach (run[i]) pending.push_back(run[i]);
        endfunction

        function void check_token(logic [3:0] kind, logic [15:0] start, logic [15:0] len,
                                  logic last);
            t_tok_entry e;
            if (pending.size() == 0) begin
                errors++;
                $display({"%0t: unexpected token, expected none, actual kind %0d ",
                          "start %0d length %0d last %0b"},
                         $time, kind, start, len, last);
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind || start !== e.start || len !== e.len || last !== e.last) begin
                errors++;
                $display({"%0t: token mismatch, expected kind %0d start %0d length %0d ",
                          "last %0b, actual kind %0d start %0d length %0d last %0b"},
                         $time, e.kind, e.start, e.len, e.last, kind, start, len, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_text_byte;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_token_kind;
    logic [15:0] o_start_offset;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    t_token_scoreboard sb;
    bit                quiet = 1'b0;
    int                sent = 0;
    int                base;

    c_like_lexer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_text_byte <= b;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        sb.note_byte(b);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] letter();
        return ($urandom_range(0, 1) == 0) ? 8'(8'h61 + $urandom_range(0, 25))
                                           : 8'(8'h41 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 3))
            0, 1:    return letter();
            2:       return 8'(8'h30 + $urandom_range(0, 9));
            default: return cll_pkg::CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] nonzero();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic random_fragment();
        logic [7:0] b;
        logic [7:0] blanks[6];
        logic [7:0] puncts[9];
        blanks = '{cll_pkg::CH_SPACE, cll_pkg::CH_TAB, cll_pkg::CH_VT, cll_pkg::CH_FF,
                   cll_pkg::CH_LF, cll_pkg::CH_CR};
        puncts = '{cll_pkg::CH_LPAREN, cll_pkg::CH_RPAREN, cll_pkg::CH_LBRACK,
                   cll_pkg::CH_RBRACK, cll_pkg::CH_LBRACE, cll_pkg::CH_RBRACE,
                   cll_pkg::CH_COLON, cll_pkg::CH_SEMI, cll_pkg::CH_STAR};
        case ($urandom_range(0, 15))
            0, 1: repeat ($urandom_range(1, 3)) send_byte(blanks[$urandom_range(0, 5)]);
            2, 3, 4: begin
                send_byte(letter());
                repeat ($urandom_range(0, 6)) send_byte(word_char());
            end
            5, 6: begin
                send_byte(cll_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_byte(cll_pkg::CH_BSLASH);
                        send_byte(nonzero());
                    end else begin
                        b = nonzero();
                        if (b == cll_pkg::CH_QUOTE || b == cll_pkg::CH_BSLASH) b = 8'h78;
                        send_byte(b);
                    end
                end
                if ($urandom_range(0, 9) != 0) send_byte(cll_pkg::CH_QUOTE);
            end
            7: begin
                send_text("//");
                repeat ($urandom_range(0, 5)) begin
                    do b = nonzero(); while (b == cll_pkg::CH_LF || b == cll_pkg::CH_CR);
                    send_byte(b);
                end
                send_byte(($urandom_range(0, 1) == 0) ? cll_pkg::CH_LF : cll_pkg::CH_CR);
            end
            8: begin
                send_text("/*");
                repeat ($urandom_range(0, 5))
                    send_byte(($urandom_range(0, 3) == 0) ? cll_pkg::CH_STAR : nonzero());
                if ($urandom_range(0, 1) == 0) send_byte(cll_pkg::CH_STAR);
                send_text("*/");
            end
            9, 10, 11: send_byte(puncts[$urandom_range(0, 8)]);
            12: begin
                send_byte(cll_pkg::CH_SLASH);
                send_byte(nonzero());
            end
            13: send_byte(($urandom_range(0, 2) == 0) ? cll_pkg::CH_NUL : nonzero());
            default: repeat (2) send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        int stall;
        stall = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 4) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_token(o_token_kind, o_start_offset, o_token_length, o_last_of_run);
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_text_byte = 8'h00;
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty stream, punctuation, lone slash, identifier end,
        // escaped quote, zero after a backslash, zero after a slash and in a comment.
        send_byte(cll_pkg::CH_NUL);
        send_text("()[]{}:;*");
        send_byte(8'hFF);
        send_text("/(ab;\"\\\"\"");
        send_text("\"\\");
        send_byte(cll_pkg::CH_NUL);
        send_byte(cll_pkg::CH_SLASH);
        send_byte(cll_pkg::CH_NUL);
        send_text("//");
        send_byte(cll_pkg::CH_NUL);

        base = sent;
        while (sent < base + 1100) begin
            if (sent >= base + 900) quiet = 1'b1;
            random_fragment();
        end
        send_byte(cll_pkg::CH_NUL);
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("c_like_lexer verification clean");
        end else begin
            $display("c_like_lexer verification failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("c_like_lexer verification failed");
        $finish;
    end
endmodule
